[sv/bsac_pkg.sv]
// shared types and constants for the banded seeded alignment cost unit
`timescale 1ns / 1ps

package bsac_pkg;

    // field widths fixed by the word formats
    localparam int COST_W     = 8;
    localparam int BASE_W     = 2;
    localparam int SYM_W      = 3;
    localparam int RESULT_W   = 16;
    localparam int OFFSET_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COST_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_COST       = 2'd0,
        CFG_MISMATCH_COST    = 2'd1,
        CFG_QUERY_GAP_COST   = 2'd2,
        CFG_SUBJECT_GAP_COST = 2'd3
    } cfg_idx_t;

    // register reset values
    localparam logic [COST_W-1:0] MATCH_COST_RST       = 8'd1;
    localparam logic [COST_W-1:0] MISMATCH_COST_RST    = 8'd3;
    localparam logic [COST_W-1:0] QUERY_GAP_COST_RST   = 8'd2;
    localparam logic [COST_W-1:0] SUBJECT_GAP_COST_RST = 8'd4;

    // band cell offsets
    localparam logic [OFFSET_W-1:0] CELL_LEFT   = 2'd0;
    localparam logic [OFFSET_W-1:0] CELL_CENTER = 2'd1;
    localparam logic [OFFSET_W-1:0] CELL_RIGHT  = 2'd2;

endpackage

[sv/bsac_if.sv]
// valid/ready channel interfaces for query columns and alignment results
`timescale 1ns / 1ps

interface bsac_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsac_pkg::BASE_W-1:0]    query_base;
    logic [bsac_pkg::SYM_W-1:0]     subj_left;
    logic [bsac_pkg::SYM_W-1:0]     subj_center;
    logic [bsac_pkg::SYM_W-1:0]     subj_right;
    logic                           first_column;
    logic                           left_blocked;
    logic                           in_seed;
    logic                           last_column;
    logic                           end_trim;

    modport source (
        output valid, query_base, subj_left, subj_center, subj_right,
               first_column, left_blocked, in_seed, last_column, end_trim,
        input  ready
    );

    modport sink (
        input  valid, query_base, subj_left, subj_center, subj_right,
               first_column, left_blocked, in_seed, last_column, end_trim,
        output ready
    );
endinterface

interface bsac_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsac_pkg::RESULT_W-1:0]  best_score;
    logic [bsac_pkg::OFFSET_W-1:0]  end_offset;

    modport source (
        output valid, best_score, end_offset,
        input  ready
    );

    modport sink (
        input  valid, best_score, end_offset,
        output ready
    );
endinterface

[sv/banded_seeded_alignment_cost_unit.sv]
// banded seeded alignment cost unit: three-cell column update and final minimum
//
// Usage: one query column word enters on the query channel per clock while ready;
// it carries the query base, the three band subject symbols and the column flags.
// A word with last_column set yields one result word on the result channel
// (best score and band offset of its first minimum); other words yield none.
// Costs are set through the cfg_we/cfg_index/cfg_wdata write port while idle.
// Path: a last column word passes from the input register through the column
// update into the final stage, then through the minimum search into the result
// register. Throughput: one column word per clock while query.ready is high; the
// column update result feeds the next column through the column score registers.
// Reset: costs return to 1/3/2/4 and the column scores to zero; no words are held.
// Stall: while the result word waits, column words without last_column keep
// flowing; a further last column word waits in the pipeline until the final
// stage frees, and query.ready falls once the input register is held.
`timescale 1ns / 1ps

module banded_seeded_alignment_cost_unit #(
    parameter int SCORE_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    bsac_in_if.sink                                query,
    bsac_out_if.source                             result,
    input  logic                                   cfg_we,
    input  logic [bsac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bsac_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam logic [SCORE_WIDTH-1:0] INF = {1'b0, {(SCORE_WIDTH-1){1'b1}}};

    // configuration registers
    logic [bsac_pkg::COST_W-1:0] match_cost_reg;
    logic [bsac_pkg::COST_W-1:0] mismatch_cost_reg;
    logic [bsac_pkg::COST_W-1:0] query_gap_cost_reg;
    logic [bsac_pkg::COST_W-1:0] subject_gap_cost_reg;

    // input stage
    logic                           in_vld_reg;
    logic [bsac_pkg::BASE_W-1:0]    in_query_reg;
    logic [bsac_pkg::SYM_W-1:0]     in_s0_reg;
    logic [bsac_pkg::SYM_W-1:0]     in_s1_reg;
    logic [bsac_pkg::SYM_W-1:0]     in_s2_reg;
    logic                           in_first_reg;
    logic                           in_blocked_reg;
    logic                           in_seed_reg;
    logic                           in_last_reg;
    logic                           in_trim_reg;

    // column state
    logic [SCORE_WIDTH-1:0]         col0_reg, col1_reg, col2_reg;
    logic [SCORE_WIDTH-1:0]         col0_next, col1_next, col2_next;

    // final column stage
    logic                           fin_vld_reg;
    logic [SCORE_WIDTH-1:0]         fin_c0_reg, fin_c1_reg, fin_c2_reg;
    logic                           fin_trim_reg;

    // result stage
    logic                           out_vld_reg;
    logic [SCORE_WIDTH-1:0]         best_reg;
    logic [bsac_pkg::OFFSET_W-1:0]  offset_reg;
    logic [SCORE_WIDTH-1:0]         best_next;
    logic [bsac_pkg::OFFSET_W-1:0]  offset_next;

    // handshake
    logic out_free, fin_go, fin_free, col_go;

    function automatic logic [SCORE_WIDTH-1:0] add_cost(
        input logic [SCORE_WIDTH-1:0]      a,
        input logic [bsac_pkg::COST_W-1:0] c
    );
        return a + SCORE_WIDTH'(c);
    endfunction

    function automatic logic [SCORE_WIDTH-1:0] pick_lower(
        input logic [SCORE_WIDTH-1:0] a,
        input logic [SCORE_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // pipeline advance
    assign out_free = !out_vld_reg || result.ready;
    assign fin_go   = fin_vld_reg && out_free;
    assign fin_free = !fin_vld_reg || out_free;
    assign col_go   = in_vld_reg && (!in_last_reg || fin_free);
    assign query.ready = !in_vld_reg || col_go;

    // cost register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_cost_reg       <= bsac_pkg::MATCH_COST_RST;
            mismatch_cost_reg    <= bsac_pkg::MISMATCH_COST_RST;
            query_gap_cost_reg   <= bsac_pkg::QUERY_GAP_COST_RST;
            subject_gap_cost_reg <= bsac_pkg::SUBJECT_GAP_COST_RST;
        end
        else if (cfg_we)
        begin
            case (bsac_pkg::cfg_idx_t'(cfg_index))
                bsac_pkg::CFG_MATCH_COST:       match_cost_reg       <= cfg_wdata;
                bsac_pkg::CFG_MISMATCH_COST:    mismatch_cost_reg    <= cfg_wdata;
                bsac_pkg::CFG_QUERY_GAP_COST:   query_gap_cost_reg   <= cfg_wdata;
                bsac_pkg::CFG_SUBJECT_GAP_COST: subject_gap_cost_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (query.ready)
        begin
            in_vld_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query.valid && query.ready)
        begin
            in_query_reg   <= query.query_base;
            in_s0_reg      <= query.subj_left;
            in_s1_reg      <= query.subj_center;
            in_s2_reg      <= query.subj_right;
            in_first_reg   <= query.first_column;
            in_blocked_reg <= query.left_blocked;
            in_seed_reg    <= query.in_seed;
            in_last_reg    <= query.last_column;
            in_trim_reg    <= query.end_trim;
        end
    end

    // column update: diagonal, subject gap, then query gap down the band
    always_comb
    begin
        logic [SCORE_WIDTH-1:0]      p0, p1, p2, c0, c1;
        logic [bsac_pkg::SYM_W-1:0]  qsym;
        logic [bsac_pkg::COST_W-1:0] d0, d1, d2;

        qsym = {1'b0, in_query_reg};
        d0 = (in_s0_reg == qsym) ? match_cost_reg : mismatch_cost_reg;
        d1 = (in_s1_reg == qsym) ? match_cost_reg : mismatch_cost_reg;
        d2 = (in_s2_reg == qsym) ? match_cost_reg : mismatch_cost_reg;
        c0 = '0;
        c1 = '0;

        if (in_first_reg)
        begin
            p0 = in_blocked_reg ? INF : '0;
            p1 = '0;
            p2 = '0;
        end
        else
        begin
            p0 = col0_reg;
            p1 = col1_reg;
            p2 = col2_reg;
        end

        if (in_seed_reg)
        begin
            col0_next = INF;
            col1_next = add_cost(p1, match_cost_reg);
            col2_next = INF;
        end
        else
        begin
            c0 = pick_lower(add_cost(p0, d0), add_cost(p1, subject_gap_cost_reg));
            c1 = pick_lower(add_cost(p1, d1), add_cost(p2, subject_gap_cost_reg));
            c1 = pick_lower(c1, add_cost(c0, query_gap_cost_reg));
            col0_next = c0;
            col1_next = c1;
            col2_next = pick_lower(add_cost(p2, d2), add_cost(c1, query_gap_cost_reg));
        end
    end

    // column state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col0_reg <= '0;
            col1_reg <= '0;
            col2_reg <= '0;
        end
        else if (col_go)
        begin
            col0_reg <= col0_next;
            col1_reg <= col1_next;
            col2_reg <= col2_next;
        end
    end

    // final column capture for last column words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (fin_free)
        begin
            fin_vld_reg <= col_go && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_free && col_go && in_last_reg)
        begin
            fin_c0_reg   <= col0_next;
            fin_c1_reg   <= col1_next;
            fin_c2_reg   <= col2_next;
            fin_trim_reg <= in_trim_reg;
        end
    end

    // first strict minimum below infinity over the usable cells
    always_comb
    begin
        best_next   = INF;
        offset_next = bsac_pkg::CELL_LEFT;
        if (fin_c0_reg < best_next)
        begin
            best_next   = fin_c0_reg;
            offset_next = bsac_pkg::CELL_LEFT;
        end
        if (fin_c1_reg < best_next)
        begin
            best_next   = fin_c1_reg;
            offset_next = bsac_pkg::CELL_CENTER;
        end
        if (!fin_trim_reg && (fin_c2_reg < best_next))
        begin
            best_next   = fin_c2_reg;
            offset_next = bsac_pkg::CELL_RIGHT;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            best_reg   <= best_next;
            offset_reg <= offset_next;
        end
    end

    // result word, low 16 bits of the score
    logic [SCORE_WIDTH+bsac_pkg::RESULT_W-1:0] best_ext;
    assign best_ext          = {{bsac_pkg::RESULT_W{1'b0}}, best_reg};
    assign result.valid      = out_vld_reg;
    assign result.best_score = best_ext[bsac_pkg::RESULT_W-1:0];
    assign result.end_offset = offset_reg;

    // a word in the input register is never dropped while the column stage waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !col_go) |=> in_vld_reg)
        else $error("input word lost while stalled");

    // seed columns leave only the centre cell usable
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_go && in_seed_reg) |=> (col0_reg == INF && col2_reg == INF))
        else $error("seed column left side cells usable");

    // a new result word only follows a captured final column
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(fin_vld_reg))
        else $error("result word without a last column");

    // the reported score never exceeds infinity and the offset stays in the band
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (best_reg <= INF && offset_reg <= bsac_pkg::CELL_RIGHT))
        else $error("result word out of range");

    // no usable cell reports offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && best_reg == INF) |-> offset_reg == bsac_pkg::CELL_LEFT)
        else $error("empty result with nonzero offset");

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the banded seeded alignment cost unit
`timescale 1ns / 1ps

module tb_top;

    // score width of the band cells and the unusable score marker
    localparam int SW = 16;
    localparam logic [SW-1:0] NO_SCORE = {1'b0, {(SW-1){1'b1}}};

    // field widths used for random draws
    localparam int QB_W = bsac_pkg::BASE_W;
    localparam int SY_W = bsac_pkg::SYM_W;
    localparam int CW   = bsac_pkg::COST_W;

    // cycles with no word moving before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // long receiver hold-off to back the pipeline up into the query channel
    localparam int HOLD_CYCLES  = 300;
    // settle time after the last result before a cost write
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [bsac_pkg::BASE_W-1:0] base;
        logic [bsac_pkg::SYM_W-1:0]  sym_l;
        logic [bsac_pkg::SYM_W-1:0]  sym_c;
        logic [bsac_pkg::SYM_W-1:0]  sym_r;
        logic                        restart;
        logic                        blocked;
        logic                        seed;
        logic                        last_col;
        logic                        trim;
    } column_word_t;

    typedef struct {
        logic [bsac_pkg::RESULT_W-1:0] score;
        logic [bsac_pkg::OFFSET_W-1:0] offset;
    } best_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we = 1'b0;
    bsac_pkg::cfg_idx_t              cfg_index = bsac_pkg::CFG_MATCH_COST;
    logic [bsac_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    bsac_in_if  query_if ();
    bsac_out_if result_if ();

    banded_seeded_alignment_cost_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor copy of the costs and the band column
    logic [CW-1:0] cost_match    = bsac_pkg::MATCH_COST_RST;
    logic [CW-1:0] cost_mismatch = bsac_pkg::MISMATCH_COST_RST;
    logic [CW-1:0] cost_qgap     = bsac_pkg::QUERY_GAP_COST_RST;
    logic [CW-1:0] cost_sgap     = bsac_pkg::SUBJECT_GAP_COST_RST;
    logic [SW-1:0] band_score [3] = '{default: '0};

    column_word_t column_q [$];
    best_word_t   best_due_q [$];

    column_word_t on_wire;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int results_seen = 0;
    int errors = 0;
    int quiet = 0;

    function automatic logic [SW-1:0] wsum(input logic [SW-1:0] a,
                                           input logic [CW-1:0] c);
        return a + SW'(c);
    endfunction

    function automatic logic [SW-1:0] lesser(input logic [SW-1:0] a,
                                             input logic [SW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // padding symbols never equal a two-bit base
    function automatic logic [CW-1:0] step_cost(input logic [SY_W-1:0] s,
                                                input logic [QB_W-1:0] q);
        return (s == {1'b0, q}) ? cost_match : cost_mismatch;
    endfunction

    // next band column from one query column word, best cell on the last column
    function automatic void advance_band(input column_word_t w);
        logic [SW-1:0] p0, p1, p2, c0, c1, c2;
        best_word_t b;
        if (w.restart)
        begin
            p0 = w.blocked ? NO_SCORE : '0;
            p1 = '0;
            p2 = '0;
        end
        else
        begin
            p0 = band_score[0];
            p1 = band_score[1];
            p2 = band_score[2];
        end
        if (w.seed)
        begin
            c0 = NO_SCORE;
            c1 = wsum(p1, cost_match);
            c2 = NO_SCORE;
        end
        else
        begin
            c0 = lesser(wsum(p0, step_cost(w.sym_l, w.base)), wsum(p1, cost_sgap));
            c1 = lesser(wsum(p1, step_cost(w.sym_c, w.base)), wsum(p2, cost_sgap));
            c1 = lesser(c1, wsum(c0, cost_qgap));
            c2 = lesser(wsum(p2, step_cost(w.sym_r, w.base)), wsum(c1, cost_qgap));
        end
        band_score[0] = c0;
        band_score[1] = c1;
        band_score[2] = c2;
        if (w.last_col)
        begin
            // only scores strictly below the marker count, first minimum wins
            b.score = NO_SCORE;
            b.offset = bsac_pkg::CELL_LEFT;
            if (c0 < b.score)
            begin
                b.score = c0;
                b.offset = bsac_pkg::CELL_LEFT;
            end
            if (c1 < b.score)
            begin
                b.score = c1;
                b.offset = bsac_pkg::CELL_CENTER;
            end
            if (!w.trim && c2 < b.score)
            begin
                b.score = c2;
                b.offset = bsac_pkg::CELL_RIGHT;
            end
            best_due_q.push_back(b);
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int draw_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    // subject symbol biased toward the query base, padding now and then
    function automatic logic [SY_W-1:0] subject_sym(input logic [QB_W-1:0] q);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return {1'b0, q};
        if (r < 90)
            return SY_W'($urandom_range(0, 3));
        if (r < 96)
            return 3'd4;
        return SY_W'($urandom_range(5, 7));
    endfunction

    // query word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_if.valid        <= 1'b0;
            query_if.query_base   <= '0;
            query_if.subj_left    <= '0;
            query_if.subj_center  <= '0;
            query_if.subj_right   <= '0;
            query_if.first_column <= 1'b0;
            query_if.left_blocked <= 1'b0;
            query_if.in_seed      <= 1'b0;
            query_if.last_column  <= 1'b0;
            query_if.end_trim     <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (query_if.valid && query_if.ready)
                advance_band(on_wire);
            if (!query_if.valid || query_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    query_if.valid <= 1'b0;
                end
                else if (column_q.size() > 0)
                begin
                    on_wire = column_q.pop_front();
                    query_if.query_base   <= on_wire.base;
                    query_if.subj_left    <= on_wire.sym_l;
                    query_if.subj_center  <= on_wire.sym_c;
                    query_if.subj_right   <= on_wire.sym_r;
                    query_if.first_column <= on_wire.restart;
                    query_if.left_blocked <= on_wire.blocked;
                    query_if.in_seed      <= on_wire.seed;
                    query_if.last_column  <= on_wire.last_col;
                    query_if.end_trim     <= on_wire.trim;
                    query_if.valid        <= 1'b1;
                    gap_left = draw_gap(src_idle_pct);
                end
                else
                    query_if.valid <= 1'b0;
            end
        end
    end

    // result word monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                results_seen++;
                if (best_due_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected: score %0d offset %0d",
                             $time, result_if.best_score, result_if.end_offset);
                end
                else
                begin
                    best_word_t b;
                    b = best_due_q.pop_front();
                    if (result_if.best_score !== b.score)
                    begin
                        errors++;
                        $display("%0t: best_score expected %0d actual %0d",
                                 $time, b.score, result_if.best_score);
                    end
                    if (result_if.end_offset !== b.offset)
                    begin
                        errors++;
                        $display("%0t: end_offset expected %0d actual %0d",
                                 $time, b.offset, result_if.end_offset);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (!held_once && results_seen >= 60)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                result_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = draw_gap(snk_idle_pct);
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_if.ready <= 1'b0;
                end
                else
                    result_if.ready <= 1'b1;
            end
        end
    end

    // hang detection
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((query_if.valid && query_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_col(input logic [QB_W-1:0] b, input logic [SY_W-1:0] sl,
                            input logic [SY_W-1:0] sc, input logic [SY_W-1:0] sr,
                            input logic rs, input logic bl, input logic sd,
                            input logic ls, input logic tr);
        column_word_t w;
        w.base = b;
        w.sym_l = sl;
        w.sym_c = sc;
        w.sym_r = sr;
        w.restart = rs;
        w.blocked = bl;
        w.seed = sd;
        w.last_col = ls;
        w.trim = tr;
        column_q.push_back(w);
    endtask

    // wait until every word is in and every result out, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (column_q.size() != 0 || query_if.valid || best_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cost(input bsac_pkg::cfg_idx_t idx, input logic [CW-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            bsac_pkg::CFG_MATCH_COST:       cost_match    = v;
            bsac_pkg::CFG_MISMATCH_COST:    cost_mismatch = v;
            bsac_pkg::CFG_QUERY_GAP_COST:   cost_qgap     = v;
            bsac_pkg::CFG_SUBJECT_GAP_COST: cost_sgap     = v;
            default: ;
        endcase
    endtask

    task automatic set_costs(input logic [CW-1:0] m, input logic [CW-1:0] mm,
                             input logic [CW-1:0] qg, input logic [CW-1:0] sg);
        drain();
        write_cost(bsac_pkg::CFG_MATCH_COST, m);
        write_cost(bsac_pkg::CFG_MISMATCH_COST, mm);
        write_cost(bsac_pkg::CFG_QUERY_GAP_COST, qg);
        write_cost(bsac_pkg::CFG_SUBJECT_GAP_COST, sg);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        src_idle_pct = pick_idle_pct();
        snk_idle_pct = pick_idle_pct();
    endtask

    // one long alignment: scores climb past the marker and wrap around
    task automatic push_long_run(input int n, input int every);
        int i;
        logic [QB_W-1:0] b;
        for (i = 0; i < n; i++)
        begin
            b = QB_W'($urandom_range(0, 3));
            push_col(b, subject_sym(b), subject_sym(b), subject_sym(b), i == 0, 1'b0, 1'b0,
                     (i % every == every - 1) || (i == n - 1), 1'($urandom_range(0, 1)));
        end
    endtask

    // mostly whole alignments with random content, some loose noise words
    task automatic add_random_columns(input int n);
        int pushed;
        int len;
        int seed_at;
        int seed_len;
        int i;
        logic [QB_W-1:0] b;
        logic rs;
        pushed = 0;
        while (pushed < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_col(QB_W'($urandom_range(0, 3)), SY_W'($urandom_range(0, 7)),
                         SY_W'($urandom_range(0, 7)), SY_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                pushed++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(1, 8);
                seed_at = $urandom_range(0, len - 1);
                seed_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
                rs = ($urandom_range(0, 4) != 0);
                for (i = 0; i < len; i++)
                begin
                    b = QB_W'($urandom_range(0, 3));
                    push_col(b, subject_sym(b), subject_sym(b), subject_sym(b),
                             (i == 0) && rs, 1'($urandom_range(0, 1)),
                             (i >= seed_at) && (i < seed_at + seed_len),
                             (i == len - 1) || ($urandom_range(0, 9) == 0),
                             1'($urandom_range(0, 1)));
                end
                pushed += len;
                if ($urandom_range(0, 7) == 0)
                begin
                    src_idle_pct = pick_idle_pct();
                    snk_idle_pct = pick_idle_pct();
                end
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        query_if.valid = 1'b0;
        query_if.query_base = '0;
        query_if.subj_left = '0;
        query_if.subj_center = '0;
        query_if.subj_right = '0;
        query_if.first_column = 1'b0;
        query_if.left_blocked = 1'b0;
        query_if.in_seed = 1'b0;
        query_if.last_column = 1'b0;
        query_if.end_trim = 1'b0;
        result_if.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed columns at the reset costs
        push_col(0, 0, 0, 0, 1, 1, 0, 1, 0);    // restart with the left cell blocked
        push_col(3, 3, 4, 7, 0, 0, 0, 1, 1);    // padding under centre and right, trimmed
        push_col(2, 2, 2, 2, 0, 1, 0, 0, 0);    // left block without restart is ignored
        push_col(1, 5, 1, 6, 0, 0, 1, 1, 0);    // seed column
        push_col(1, 1, 1, 1, 0, 0, 1, 1, 1);    // seed again, trimmed
        push_col(1, 1, 1, 1, 1, 0, 1, 1, 1);    // restart straight into a seed
        push_col(2, 7, 7, 7, 1, 0, 0, 1, 0);    // nothing but padding
        push_col(3, 3, 3, 3, 0, 0, 0, 0, 0);
        push_col(0, 4, 0, 4, 0, 0, 0, 1, 0);    // continues after a result
        push_col(3, 0, 1, 2, 0, 0, 0, 0, 0);
        push_col(2, 6, 5, 4, 0, 1, 0, 1, 1);
        push_col(0, 0, 4, 0, 1, 1, 0, 0, 0);
        push_col(1, 4, 4, 4, 0, 0, 0, 1, 0);
        push_col(3, 3, 7, 3, 0, 0, 1, 0, 0);
        push_col(3, 3, 3, 3, 0, 0, 0, 1, 1);
        push_col(0, 0, 0, 0, 1, 0, 0, 1, 0);    // back-to-back results
        push_col(0, 1, 0, 2, 1, 1, 0, 1, 0);
        push_col(2, 2, 3, 2, 1, 0, 0, 1, 1);
        add_random_columns(120);

        // extremes, then mixed and random cost settings
        set_costs(8'd0, 8'd0, 8'd0, 8'd0);
        add_random_columns(100);

        set_costs(8'd255, 8'd255, 8'd255, 8'd255);
        push_long_run(275, 20);
        add_random_columns(70);

        set_costs(8'd0, 8'd255, 8'd255, 8'd0);
        add_random_columns(100);

        set_costs(8'd255, 8'd0, 8'd0, 8'd255);
        add_random_columns(100);

        repeat (3)
        begin
            set_costs(CW'($urandom_range(0, 255)), CW'($urandom_range(0, 255)),
                      CW'($urandom_range(0, 255)), CW'($urandom_range(0, 255)));
            add_random_columns(100);
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
